### design/mahs_pkg.sv
// Types, codes and constants shared by the multi-axis homing sequencer.
// No dependencies; used by mahs_result_buf and the top level.
`timescale 1ns / 1ps

package mahs_pkg;

    localparam int OP_W       = 2;
    localparam int MASK_W     = 12;
    localparam int AXNUM_W    = 4;
    localparam int ACT_W      = 3;
    localparam int DIST_W     = 32;
    localparam int SPEED_W    = 32;
    localparam int SSPEED_W   = 16;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CNT_W-1:0]   CNT_MAX = {CNT_W{1'b1}};

    localparam logic [DIST_W-1:0]  SEEK_DIST_RST     = 32'd1600;
    localparam logic [SPEED_W-1:0] OFFSET_SPEED_RST  = 32'd5000;
    localparam logic [CNT_W-1:0]   TIMEOUT_LIMIT_RST = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEEK_DIST     = 2'd0,
        CFG_OFFSET_SPEED  = 2'd1,
        CFG_TIMEOUT_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_HOME = 2'd1,
        OP_SCAN = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_FOUND       = 3'd0,
        ACT_OFFSET_MOVE = 3'd1,
        ACT_OFFSET_DONE = 3'd2,
        ACT_TIMEOUT     = 3'd3,
        ACT_SEEK        = 3'd4,
        ACT_AT_HOME     = 3'd5,
        ACT_REJECT      = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_SEEK     = 2'd1,
        PH_SEEK_OFS = 2'd2,
        PH_OFS_MOVE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_seq_state;

    typedef struct packed {
        logic [AXNUM_W-1:0]       axis;
        t_action                  action;
        logic signed [DIST_W-1:0] distance;
        logic [SPEED_W-1:0]       speed;
    } t_result;

    typedef struct packed {
        logic room;
        logic pend;
    } t_buf_stat;

endpackage

### design/mahs_result_buf.sv
// Result buffer: one pending slot plus the output register.
// Holds the newest result back so the final one of a transaction is tagged last.
// Depends on mahs_pkg.
`timescale 1ns / 1ps

module mahs_result_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mahs_pkg::t_result  i_res,
    input  logic               i_flush,
    output mahs_pkg::t_buf_stat o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mahs_pkg::t_result  o_res,
    output logic               o_last
);
    import mahs_pkg::*;

    logic    r_pend_vld;
    t_result r_pend;
    logic    r_out_vld;
    t_result r_out;
    logic    r_out_last;
    logic    w_out_free;

    assign w_out_free  = !r_out_vld || i_out_ready;
    assign o_stat.room = !r_pend_vld || w_out_free;
    assign o_stat.pend = r_pend_vld;
    assign o_out_valid = r_out_vld;
    assign o_res       = r_out;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (i_push) begin
            r_pend_vld <= 1'b1;
            if (r_pend_vld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end else if (i_flush && r_pend_vld && w_out_free) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pend <= i_res;
            if (r_pend_vld) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end else if (i_flush && r_pend_vld && w_out_free) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

endmodule

### design/multi_axis_homing_sequencer_top.sv
// Multi-axis homing sequencer, top level: sequencer, per-axis state, config registers.
// Depends on mahs_pkg and mahs_result_buf.
`timescale 1ns / 1ps

// A transaction is taken only while o_in_ready is high. The sequencer then walks
// the axes one per cycle, while no walk step waits as described below, through a
// single shared per-axis evaluation unit. A tick or a scan walks all AXES axes; a
// home request walks first_axis to last_axis. A walk step that makes a result waits
// while both the held result and the output register are full and the output is
// not taken; the final drain of the held result waits the same way. A rejected
// request goes through the flush state; an empty range or an unused op code leaves
// the sequencer idle. Timeout counters saturate at 65535.
// There is no clearing pass after reset.
module multi_axis_homing_sequencer_top #(
    parameter int AXES = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [mahs_pkg::OP_W-1:0]               i_op,
    input  logic [mahs_pkg::MASK_W-1:0]             i_home_clear,
    input  logic [mahs_pkg::MASK_W-1:0]             i_axis_idle,
    input  logic [mahs_pkg::AXNUM_W-1:0]            i_first_axis,
    input  logic [mahs_pkg::AXNUM_W-1:0]            i_last_axis,
    input  logic [mahs_pkg::SSPEED_W-1:0]           i_seek_speed,
    input  logic signed [mahs_pkg::DIST_W-1:0]      i_home_offset,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [mahs_pkg::AXNUM_W-1:0]            o_axis,
    output logic [mahs_pkg::ACT_W-1:0]              o_action,
    output logic signed [mahs_pkg::DIST_W-1:0]      o_distance,
    output logic [mahs_pkg::SPEED_W-1:0]            o_speed,
    output logic                                    o_last,
    input  logic                                    i_cfg_we,
    input  logic [mahs_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [mahs_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import mahs_pkg::*;

    localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;

    t_seq_state r_state;
    t_seq_state n_state;

    logic signed [DIST_W-1:0] r_seek_dist;
    logic [SPEED_W-1:0]       r_offset_speed;
    logic [CNT_W-1:0]         r_timeout_limit;

    t_op                      r_op;
    logic [MASK_W-1:0]        r_clear;
    logic [MASK_W-1:0]        r_idle;
    logic [SSPEED_W-1:0]      r_sspeed;
    logic signed [DIST_W-1:0] r_offs_in;
    logic [IW-1:0]            r_idx;
    logic [IW-1:0]            r_end;

    t_phase                   r_phase [AXES];
    logic [CNT_W-1:0]         r_cnt   [AXES];
    logic signed [DIST_W-1:0] r_offs  [AXES];

    t_phase                   n_phase;
    logic [CNT_W-1:0]         n_cnt;
    logic signed [DIST_W-1:0] n_offs;

    logic        w_acc;
    logic        w_bad;
    logic        w_empty;
    logic        w_step;
    logic        w_emit;
    logic        w_push;
    logic        w_flush;
    t_result     w_axis_res;
    t_result     w_push_res;
    t_result     w_out_res;
    t_buf_stat   w_stat;
    logic [MASK_W-1:0] w_clear_sh;
    logic [MASK_W-1:0] w_idle_sh;
    logic        w_at_home;
    logic        w_idle_bit;
    logic [AXNUM_W-1:0] w_axis_num;

    assign w_acc   = i_in_valid && o_in_ready;
    assign w_bad   = (i_first_axis == '0) || (i_last_axis == '0) ||
                     (32'(i_first_axis) > AXES) || (32'(i_last_axis) > AXES);
    assign w_empty = i_first_axis > i_last_axis;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (t_op'(i_op))
                        OP_TICK, OP_SCAN: n_state = ST_WALK;
                        OP_HOME: begin
                            if (w_bad) begin
                                n_state = ST_FLUSH;
                            end else if (!w_empty) begin
                                n_state = ST_WALK;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (w_step && (r_idx == r_end)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!w_stat.pend) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        w_flush    = (r_state == ST_FLUSH);
        w_step     = (r_state == ST_WALK) && (!w_emit || w_stat.room);
        w_push     = (w_step && w_emit) ||
                     (w_acc && (t_op'(i_op) == OP_HOME) && w_bad);
        if (r_state == ST_WALK) begin
            w_push_res = w_axis_res;
        end else begin
            w_push_res.axis     = '0;
            w_push_res.action   = ACT_REJECT;
            w_push_res.distance = '0;
            w_push_res.speed    = '0;
        end
    end

    assign w_clear_sh = r_clear >> r_idx;
    assign w_idle_sh  = r_idle >> r_idx;
    assign w_at_home  = !w_clear_sh[0];
    assign w_idle_bit = w_idle_sh[0];
    assign w_axis_num = AXNUM_W'(32'(r_idx) + 32'd1);

    // shared per-axis evaluation
    always_comb begin
        n_phase             = r_phase[r_idx];
        n_cnt               = r_cnt[r_idx];
        n_offs              = r_offs[r_idx];
        w_emit              = 1'b0;
        w_axis_res.axis     = w_axis_num;
        w_axis_res.action   = ACT_FOUND;
        w_axis_res.distance = '0;
        w_axis_res.speed    = '0;
        case (r_op)
            OP_TICK: begin
                if (r_cnt[r_idx] != CNT_MAX) begin
                    n_cnt = r_cnt[r_idx] + 1'b1;
                end
            end
            OP_HOME: begin
                if (w_at_home) begin
                    if (r_offs_in == '0) begin
                        w_emit            = 1'b1;
                        w_axis_res.action = ACT_AT_HOME;
                    end else begin
                        n_offs  = r_offs_in;
                        n_phase = PH_SEEK_OFS;
                    end
                end else begin
                    if (r_phase[r_idx] == PH_IDLE) begin
                        n_cnt   = '0;
                        n_phase = PH_SEEK;
                    end
                    if (r_offs_in != '0) begin
                        n_offs  = r_offs_in;
                        n_phase = PH_SEEK_OFS;
                    end
                    w_emit              = 1'b1;
                    w_axis_res.action   = ACT_SEEK;
                    w_axis_res.distance = r_seek_dist;
                    w_axis_res.speed    = SPEED_W'(r_sspeed);
                end
            end
            OP_SCAN: begin
                if ((r_phase[r_idx] == PH_SEEK) && w_at_home) begin
                    n_phase           = PH_IDLE;
                    w_emit            = 1'b1;
                    w_axis_res.action = ACT_FOUND;
                end else if ((r_phase[r_idx] == PH_SEEK_OFS) && w_at_home) begin
                    n_phase             = PH_OFS_MOVE;
                    w_emit              = 1'b1;
                    w_axis_res.action   = ACT_OFFSET_MOVE;
                    w_axis_res.distance = r_offs[r_idx];
                    w_axis_res.speed    = r_offset_speed;
                end else if ((r_phase[r_idx] == PH_OFS_MOVE) && w_idle_bit) begin
                    n_phase           = PH_IDLE;
                    w_emit            = 1'b1;
                    w_axis_res.action = ACT_OFFSET_DONE;
                end else if ((r_phase[r_idx] == PH_SEEK) &&
                             (r_cnt[r_idx] > r_timeout_limit)) begin
                    n_cnt             = '0;
                    n_phase           = PH_IDLE;
                    w_emit            = 1'b1;
                    w_axis_res.action = ACT_TIMEOUT;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seek_dist     <= SEEK_DIST_RST;
            r_offset_speed  <= OFFSET_SPEED_RST;
            r_timeout_limit <= TIMEOUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SEEK_DIST:     r_seek_dist     <= i_cfg_data;
                CFG_OFFSET_SPEED:  r_offset_speed  <= i_cfg_data;
                CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data[CNT_W-1:0];
                default: begin
                    r_timeout_limit <= r_timeout_limit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op      <= t_op'(i_op);
            r_clear   <= i_home_clear;
            r_idle    <= i_axis_idle;
            r_sspeed  <= i_seek_speed;
            r_offs_in <= i_home_offset;
            if (t_op'(i_op) == OP_HOME) begin
                r_idx <= IW'(i_first_axis - 1'b1);
                r_end <= IW'(i_last_axis - 1'b1);
            end else begin
                r_idx <= '0;
                r_end <= IW'(AXES - 1);
            end
        end else if (w_step && (r_idx != r_end)) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_phase[k] <= PH_IDLE;
                r_cnt[k]   <= '0;
            end
        end else if (w_step) begin
            r_phase[r_idx] <= n_phase;
            r_cnt[r_idx]   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_offs[r_idx] <= n_offs;
        end
    end

    mahs_result_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_res       (w_push_res),
        .i_flush     (w_flush),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_out_res),
        .o_last      (o_last)
    );

    assign o_axis     = w_out_res.axis;
    assign o_action   = w_out_res.action;
    assign o_distance = w_out_res.distance;
    assign o_speed    = w_out_res.speed;

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_stat.pend)
        else $error("held result left behind at idle");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_idx <= r_end))
        else $error("walk index past range end");

    a_reject_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_op == OP_HOME) && w_bad) |=> (w_stat.pend && (r_state == ST_FLUSH)))
        else $error("rejected request not held for output");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_stat.room)
        else $error("result pushed with no room");

endmodule
